/* design/obvc_pkg.sv */
package obvc_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CW = 28;      // CORDIC x/y datapath width
	localparam int DIV_W = 33;   // dividend width of the shared divider

	localparam logic [1:0] ST_CMD  = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_FAR  = 2'd2;

	localparam logic [31:0] ATAN_TAB [24] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef enum logic [2:0] {
		REG_TARGET   = 3'd0,
		REG_MAX_RATE = 3'd1,
		REG_CAPTURE  = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_MAX_LIN  = 3'd4,
		REG_MAX_SPIN = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] target_angle;
		logic [14:0] max_orbit_rate;
		logic [14:0] capture_distance;
		logic [14:0] orbit_radius;
		logic [14:0] max_linear_speed;
		logic [14:0] max_spin_rate;
	} cfg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_VEC, S_MAG, S_CHK, S_ROT, S_FX, S_FXCHK, S_FXDIV, S_FXW,
		S_SDCHK, S_SDIV, S_SDW, S_SPIN1, S_SPIN2, S_OUT_CMD, S_OUT_FAR
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_SKIP, OP_LOAD, OP_VEC, OP_MAG, OP_PREP, OP_ROT, OP_FX,
		OP_DIVLD_FX, OP_DIVLD_SD, OP_DIVSTEP, OP_FXW, OP_SDW, OP_SIDE_MAX,
		OP_SWA, OP_SPIN, OP_OUT_CMD, OP_OUT_FAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [5:0] idx;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic far;
		logic fx_big;
		logic side_big;
		logic s_zero;
		logic out_free;
	} sts_t;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767) r = 16'sd32767;
		else if (v < -24'sd32768) r = -16'sd32768;
		else r = v[15:0];
		return r;
	endfunction

endpackage

/* design/orbit_ball_velocity_controller_unit.sv */
// channel | direction | handshake          | word
// input   | in        | in_valid/in_stall  | frame_number .. ball_y
// output  | out       | out_valid/out_stall| status .. spin_speed
// config  | in        | APB write/read     | six registers at 4*i
//
// Skipped frames are written to the output register when they are taken.
// A command runs CORDIC vectoring and rotation, plus a rescale
// through the shared bit-serial divider where a speed is too large.
// A far ball answers after vectoring and the distance check.
// One item is processed at a time; the next non-skipped item can be
// taken while a result waits in the output register. Reset clears the frame record and loads the config defaults.
module orbit_ball_velocity_controller_unit #(
	parameter int CORDIC_STEPS = obvc_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [31:0] frame_number,
	input  logic robot_present,
	input  logic signed [15:0] robot_x,
	input  logic signed [15:0] robot_y,
	input  logic signed [15:0] robot_heading,
	input  logic signed [15:0] ball_x,
	input  logic signed [15:0] ball_y,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic command_valid,
	output logic signed [15:0] forward_speed,
	output logic signed [15:0] sideways_speed,
	output logic signed [15:0] spin_speed
);
	import obvc_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	obvc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	obvc_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	obvc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .sts(sts),
		.frame_number(frame_number), .robot_present(robot_present),
		.robot_x(robot_x), .robot_y(robot_y), .robot_heading(robot_heading),
		.ball_x(ball_x), .ball_y(ball_y), .out_stall(out_stall), .out_valid(out_valid),
		.status(status), .command_valid(command_valid), .forward_speed(forward_speed),
		.sideways_speed(sideways_speed), .spin_speed(spin_speed)
	);

endmodule

/* design/obvc_regs.sv */
module obvc_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output obvc_pkg::cfg_t cfg
);
	import obvc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_angle     <= 16'sd21903;
			cfg_q.max_orbit_rate   <= 15'd8192;
			cfg_q.capture_distance <= 15'd430;
			cfg_q.orbit_radius     <= 15'd418;
			cfg_q.max_linear_speed <= 15'd1638;
			cfg_q.max_spin_rate    <= 15'd12288;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_TARGET:   cfg_q.target_angle     <= pwdata[15:0];
				REG_MAX_RATE: cfg_q.max_orbit_rate   <= pwdata[14:0];
				REG_CAPTURE:  cfg_q.capture_distance <= pwdata[14:0];
				REG_RADIUS:   cfg_q.orbit_radius     <= pwdata[14:0];
				REG_MAX_LIN:  cfg_q.max_linear_speed <= pwdata[14:0];
				REG_MAX_SPIN: cfg_q.max_spin_rate    <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_TARGET:   prdata = {16'd0, cfg_q.target_angle};
			REG_MAX_RATE: prdata = {17'd0, cfg_q.max_orbit_rate};
			REG_CAPTURE:  prdata = {17'd0, cfg_q.capture_distance};
			REG_RADIUS:   prdata = {17'd0, cfg_q.orbit_radius};
			REG_MAX_LIN:  prdata = {17'd0, cfg_q.max_linear_speed};
			REG_MAX_SPIN: prdata = {17'd0, cfg_q.max_spin_rate};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

/* design/obvc_ctrl.sv */
module obvc_ctrl #(
	parameter int CORDIC_STEPS = obvc_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  obvc_pkg::sts_t sts,
	output obvc_pkg::cmd_t cmd
);
	import obvc_pkg::*;

	localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);
	localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);

	state_t state_q, state_d;
	logic [5:0] cnt_q;
	logic accept;

	assign in_stall = (state_q != S_IDLE) || (sts.skip && !sts.out_free);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 6'd0 : cnt_q + 6'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (accept && !sts.skip) state_d = S_VEC;
			S_VEC:     if (cnt_q == CORDIC_LAST) state_d = S_MAG;
			S_MAG:     state_d = S_CHK;
			S_CHK:     state_d = sts.far ? S_OUT_FAR : S_ROT;
			S_ROT:     if (cnt_q == CORDIC_LAST) state_d = S_FX;
			S_FX:      state_d = S_FXCHK;
			S_FXCHK:   state_d = sts.fx_big ? S_FXDIV : S_SDCHK;
			S_FXDIV:   if (cnt_q == DIV_LAST) state_d = S_FXW;
			S_FXW:     state_d = S_SDCHK;
			S_SDCHK:   state_d = (sts.side_big && !sts.s_zero) ? S_SDIV : S_SPIN1;
			S_SDIV:    if (cnt_q == DIV_LAST) state_d = S_SDW;
			S_SDW:     state_d = S_SPIN1;
			S_SPIN1:   state_d = S_SPIN2;
			S_SPIN2:   state_d = S_OUT_CMD;
			S_OUT_CMD: if (sts.out_free) state_d = S_IDLE;
			S_OUT_FAR: if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.idx = cnt_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:    if (accept) cmd.op = sts.skip ? OP_SKIP : OP_LOAD;
			S_VEC:     cmd.op = OP_VEC;
			S_MAG:     cmd.op = OP_MAG;
			S_CHK:     cmd.op = OP_PREP;
			S_ROT:     cmd.op = OP_ROT;
			S_FX:      cmd.op = OP_FX;
			S_FXCHK:   if (sts.fx_big) cmd.op = OP_DIVLD_FX;
			S_FXDIV:   cmd.op = OP_DIVSTEP;
			S_FXW:     cmd.op = OP_FXW;
			S_SDCHK: begin
				if (sts.side_big) cmd.op = sts.s_zero ? OP_SIDE_MAX : OP_DIVLD_SD;
			end
			S_SDIV:    cmd.op = OP_DIVSTEP;
			S_SDW:     cmd.op = OP_SDW;
			S_SPIN1:   cmd.op = OP_SWA;
			S_SPIN2:   cmd.op = OP_SPIN;
			S_OUT_CMD: if (sts.out_free) cmd.op = OP_OUT_CMD;
			S_OUT_FAR: if (sts.out_free) cmd.op = OP_OUT_FAR;
			default:   cmd.op = OP_NONE;
		endcase
	end

	a_load_starts_vec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |=> state_q == S_VEC && cnt_q == 6'd0)
		else $error("load did not start vectoring");
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall)
		else $error("input taken while busy");
	a_far_from_chk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT_FAR |-> $past(state_q) == S_CHK || $past(state_q) == S_OUT_FAR)
		else $error("far result from wrong state");

endmodule

/* design/obvc_dp.sv */
module obvc_dp (
	input  logic clk,
	input  logic arst_n,
	input  obvc_pkg::cfg_t cfg,
	input  obvc_pkg::cmd_t cmd,
	output obvc_pkg::sts_t sts,
	input  logic [31:0] frame_number,
	input  logic robot_present,
	input  logic signed [15:0] robot_x,
	input  logic signed [15:0] robot_y,
	input  logic signed [15:0] robot_heading,
	input  logic signed [15:0] ball_x,
	input  logic signed [15:0] ball_y,
	input  logic out_stall,
	output logic out_valid,
	output logic [1:0] status,
	output logic command_valid,
	output logic signed [15:0] forward_speed,
	output logic signed [15:0] sideways_speed,
	output logic signed [15:0] spin_speed
);
	import obvc_pkg::*;

	logic [31:0] last_frame_q;
	logic seen_q;
	logic signed [15:0] hd_q;
	logic zero_q, neg_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [16:0] d_q;
	logic [31:0] bear_q;
	logic signed [19:0] s_q;
	logic signed [17:0] rate_q;
	logic signed [19:0] fx_q;
	logic signed [15:0] side_q;
	logic [DIV_W-1:0] num_q;
	logic [16:0] rem_q, den_q;
	logic signed [18:0] swa_q, spin_q;
	logic out_valid_q, cmdv_q;
	logic [1:0] status_q;
	logic signed [15:0] fwd_o_q, side_o_q, spin_o_q;

	// load
	logic signed [16:0] dx, dy;
	logic signed [17:0] ax, ay;
	// shared CORDIC step
	logic signed [CW-1:0] xs, ys;
	logic signed [33:0] at;
	logic ccw;
	// products and roundings
	logic signed [44:0] mag_p, mag_r;
	logic signed [19:0] sdiff, s_w;
	logic [31:0] phi;
	logic signed [33:0] zs;
	logic signed [15:0] e;
	logic signed [33:0] rate_p, rate_r;
	logic signed [17:0] rate_w;
	logic signed [CW-1:0] x_eff;
	logic signed [47:0] fx_p, fx_r;
	logic signed [33:0] side_p, side_r;
	logic [31:0] fxm, sdm;
	logic [17:0] trial;
	logic trial_ok;
	logic [15:0] quot;
	logic signed [34:0] swa_p, swa_r;
	logic [31:0] diff;
	logic signed [50:0] spin_p, spin_r;
	logic signed [19:0] abs_s;
	logic signed [18:0] msr;
	logic signed [15:0] spin_c;
	logic out_load;

	assign dx = {ball_x[15], ball_x} - {robot_x[15], robot_x};
	assign dy = {ball_y[15], ball_y} - {robot_y[15], robot_y};
	assign ax = dx[16] ? 18'sd0 - 18'(dx) : 18'(dx);
	assign ay = dx[16] ? 18'sd0 - 18'(dy) : 18'(dy);

	assign xs = x_q >>> cmd.idx[4:0];
	assign ys = y_q >>> cmd.idx[4:0];
	assign at = {2'b00, ATAN_TAB[cmd.idx[4:0]]};
	// x -= ys, y += xs, z -= atan
	assign ccw = (cmd.op == OP_VEC) ? !(y_q > 0) : !z_q[33];

	assign mag_p = 45'(x_q) * 45'sd39797;
	assign mag_r = (mag_p + 45'sd8388608) >>> 24;

	assign sdiff = {3'b000, d_q} - {5'b00000, cfg.orbit_radius};
	assign s_w = (d_q == 17'd0) ? 20'sd0 : (sdiff <<< 1) + sdiff;
	assign phi = bear_q - {hd_q, 16'h0000};
	assign zs = {{2{phi[31]}}, phi};
	assign e = hd_q - cfg.target_angle;
	assign rate_p = 34'(e) * 34'sd51472;
	assign rate_r = (rate_p + 34'sd32768) >>> 16;
	assign rate_w = ($signed(rate_r[17:0]) > $signed({3'b000, cfg.max_orbit_rate}))
		? $signed({3'b000, cfg.max_orbit_rate}) : $signed(rate_r[17:0]);

	assign x_eff = neg_q ? -x_q : x_q;
	assign fx_p = 48'(s_q) * 48'(x_eff);
	assign fx_r = (fx_p + 48'sd8388608) >>> 24;
	assign side_p = 34'(rate_q) * $signed({19'd0, cfg.orbit_radius});
	assign side_r = (side_p + 34'sd2048) >>> 12;

	assign abs_s = s_q[19] ? -s_q : s_q;
	assign fxm = 32'(fx_q[16:0]) * 32'(cfg.max_linear_speed);
	assign sdm = 32'(side_q[14:0]) * 32'(cfg.max_linear_speed);
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign trial_ok = trial >= {1'b0, den_q};
	assign quot = (num_q > DIV_W'(32767)) ? 16'd32767 : num_q[15:0];

	assign swa_p = 35'(side_q) * 35'sd166887;
	assign swa_r = (swa_p + 35'sd32768) >>> 16;
	assign diff = bear_q - {swa_q[15:0], 16'h0000} - {hd_q, 16'h0000};
	assign spin_p = 51'($signed(diff)) * 51'sd154416;
	assign spin_r = (spin_p + 51'sd2147483648) >>> 32;

	assign msr = $signed({4'b0000, cfg.max_spin_rate});
	always_comb begin
		if (spin_q > msr) spin_c = msr[15:0];
		else if (spin_q < -msr) spin_c = 16'(-msr);
		else spin_c = spin_q[15:0];
	end

	assign out_load = (cmd.op == OP_SKIP) || (cmd.op == OP_OUT_CMD) || (cmd.op == OP_OUT_FAR);

	assign sts.skip = !robot_present || (seen_q && frame_number == last_frame_q);
	assign sts.far = d_q >= {2'b00, cfg.capture_distance};
	assign sts.fx_big = fx_q > $signed({5'b00000, cfg.max_linear_speed});
	assign sts.side_big = side_q > $signed({1'b0, cfg.max_linear_speed});
	assign sts.s_zero = (s_q == 20'sd0);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_frame_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD) begin
				seen_q <= 1'b1;
				last_frame_q <= frame_number;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				hd_q <= robot_heading;
				zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
				x_q <= {{2{ax[17]}}, ax, 8'h00};
				y_q <= {{2{ay[17]}}, ay, 8'h00};
				z_q <= dx[16] ? 34'sh080000000 : 34'sd0;
			end
			OP_VEC, OP_ROT: begin
				if (ccw) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			OP_MAG: begin
				d_q <= zero_q ? 17'd0 : mag_r[16:0];
				bear_q <= zero_q ? 32'd0 : z_q[31:0];
			end
			OP_PREP: begin
				s_q <= s_w;
				rate_q <= rate_w;
				x_q <= CW'(39797 * 256);
				y_q <= '0;
				if (zs > 34'sh040000000) begin
					z_q <= zs - 34'sh080000000;
					neg_q <= 1'b1;
				end else if (zs < -34'sh040000000) begin
					z_q <= zs + 34'sh080000000;
					neg_q <= 1'b1;
				end else begin
					z_q <= zs;
					neg_q <= 1'b0;
				end
			end
			OP_FX: begin
				fx_q <= fx_r[19:0];
				side_q <= sat16(side_r[23:0]);
			end
			OP_DIVLD_FX: begin
				num_q <= {1'b0, fxm};
				rem_q <= '0;
				den_q <= abs_s[16:0];
			end
			OP_DIVLD_SD: begin
				num_q <= {1'b0, sdm};
				rem_q <= '0;
				den_q <= abs_s[16:0];
			end
			OP_DIVSTEP: begin
				rem_q <= trial_ok ? 17'(trial - {1'b0, den_q}) : trial[16:0];
				num_q <= {num_q[DIV_W-2:0], trial_ok};
			end
			OP_FXW: fx_q <= {4'h0, quot};
			OP_SDW: side_q <= quot;
			OP_SIDE_MAX: side_q <= 16'sd32767;
			OP_SWA: swa_q <= swa_r[18:0];
			OP_SPIN: spin_q <= spin_r[18:0];
			OP_OUT_CMD: begin
				status_q <= ST_CMD;
				cmdv_q <= 1'b1;
				fwd_o_q <= sat16(24'(fx_q));
				side_o_q <= side_q;
				spin_o_q <= spin_c;
			end
			OP_OUT_FAR, OP_SKIP: begin
				status_q <= (cmd.op == OP_SKIP) ? ST_SKIP : ST_FAR;
				cmdv_q <= 1'b0;
				fwd_o_q <= '0;
				side_o_q <= '0;
				spin_o_q <= '0;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign command_valid = cmdv_q;
	assign forward_speed = fwd_o_q;
	assign sideways_speed = side_o_q;
	assign spin_speed = spin_o_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || !out_stall)
		else $error("result word overwritten while stalled");
	a_cmdv_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cmdv_q |-> status_q == ST_CMD)
		else $error("command flag without command status");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DIVSTEP |=> rem_q < den_q)
		else $error("divider remainder out of range");
	a_frame_kept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SKIP |=> $stable(last_frame_q))
		else $error("skipped frame changed frame record");

endmodule
